@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SPT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");
// Property must never hold outside reset.
`define SPT_ASSERT_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) not (prop)) \
        else $error("%m: forbidden condition seen");
`else
`define SPT_ASSERT(lbl, clk, rstn, prop)
`define SPT_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

@@ design/spt_pkg.sv @@
// Package for the shortest-path tree block: widths, defaults, register map, sequencer states.
package spt_pkg;

    // Field widths
    localparam int unsigned VERTEX_W = 5;
    localparam int unsigned EDGE_COST_W = 24;
    localparam int unsigned TOTAL_W = 32;
    localparam int unsigned CFG_W = 6;

    // Parameter defaults and hard limit on live vertices
    localparam int unsigned MAX_VERTICES_DEF = 32;
    localparam int unsigned COST_BITS_DEF = 24;
    localparam int unsigned HW_VERTEX_LIMIT = 32;

    // Configuration port
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;
    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 6'd32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_EMIT
    } t_state;

endpackage

@@ design/shortest_path_tree.sv @@
// Shortest-path tree from vertex 0: edge store, Dijkstra round sequencer, result emitter.
//
// Edges are loaded one transfer per cycle (start high while busy low) into an
// adjacency-cost RAM addressed by {from, to}. The transfer with i_last_edge set is
// stored and then starts the tree search, during which busy stays high. Each round
// walks every (target, source) pair once through the RAM's single read port, one
// pair per cycle, into one shared saturating adder and compare. With n the live
// vertex count, there are at most n rounds (one per settled vertex plus a final
// round that finds nothing). Then n results go out on consecutive cycles, each
// marked by o_result_valid for one cycle; the receiver cannot stall them, so it
// must take every cycle's result. Afterwards the edge RAM is wiped by a clearing
// pass of one entry per cycle over all 2**(2*ceil(log2 MAX_VERTICES)) entries
// (1024 at the default size); the same pass runs after reset.
// vertex_count may be written through the APB port at any time busy is low.
module shortest_path_tree #(
    parameter int unsigned MAX_VERTICES = spt_pkg::MAX_VERTICES_DEF,
    parameter int unsigned COST_BITS = spt_pkg::COST_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spt_pkg::APB_AW-1:0]        paddr,
    input  logic [spt_pkg::APB_DW-1:0]        pwdata,
    output logic [spt_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    // edge input
    input  logic                              start,
    output logic                              busy,
    input  logic [spt_pkg::VERTEX_W-1:0]      i_from_vertex,
    input  logic [spt_pkg::VERTEX_W-1:0]      i_to_vertex,
    input  logic [spt_pkg::EDGE_COST_W-1:0]   i_edge_cost,
    input  logic                              i_last_edge,
    // results
    output logic                              o_result_valid,
    output logic [spt_pkg::VERTEX_W-1:0]      o_vertex_index,
    output logic [spt_pkg::VERTEX_W-1:0]      o_predecessor,
    output logic [spt_pkg::TOTAL_W-1:0]       o_total_cost,
    output logic                              o_reached,
    output logic                              o_last_result
);
    import spt_pkg::*;

    `include "assert_macros.svh"

    // Derived sizes
    localparam int unsigned LIVE_MAX =
        (MAX_VERTICES < HW_VERTEX_LIMIT) ? MAX_VERTICES : HW_VERTEX_LIMIT;
    localparam int unsigned VIW = $clog2(LIVE_MAX);
    localparam int unsigned AVW = $clog2(MAX_VERTICES);
    localparam int unsigned MEM_AW = 2 * AVW;
    localparam int unsigned MEM_DEPTH = 1 << MEM_AW;
    localparam int unsigned MEM_W = COST_BITS + 1;

    // Control state
    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_vertex_count;
    logic [MEM_AW-1:0]     r_clr;
    logic [VIW-1:0]        r_s, r_t, r_v, r_last;
    logic [LIVE_MAX-1:0]   r_settled;
    logic                  r_found;
    logic                  r_p_vld;
    logic                  r_result_valid;

    // Payload state
    logic [TOTAL_W-1:0]    r_path_cost [LIVE_MAX];
    logic [VIW-1:0]        r_pred [LIVE_MAX];
    logic                  r_p_ok;
    logic [VIW-1:0]        r_p_s, r_p_t;
    logic [TOTAL_W-1:0]    r_p_pc;
    logic [TOTAL_W-1:0]    r_best;
    logic [VIW-1:0]        r_best_s, r_best_t;
    logic [VERTEX_W-1:0]   r_out_index, r_out_pred;
    logic [TOTAL_W-1:0]    r_out_cost;
    logic                  r_out_reached, r_out_last;

    // Combinational signals
    logic                  w_accept, w_cfg_wr, w_in_range;
    logic                  w_s_end, w_t_end;
    logic [CFG_W-1:0]      w_n_live;
    logic [VIW-1:0]        w_last_idx;
    logic [31:0]           w_cost_ext;
    logic [COST_BITS-1:0]  w_cost;
    logic [VERTEX_W+AVW-1:0] w_from_ext, w_to_ext;
    logic [VIW+AVW-1:0]    w_s_ext, w_t_ext;
    logic [VERTEX_W+VIW-1:0] w_v_ext, w_pred_ext;
    logic                  w_mem_we;
    logic [MEM_AW-1:0]     w_mem_waddr, w_mem_raddr;
    logic [MEM_W-1:0]      w_mem_wdata, w_mem_rdata;
    logic [TOTAL_W:0]      w_sum;
    logic [TOTAL_W-1:0]    w_cand;
    logic                  w_better;

    // Handshakes
    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
    assign prdata   = (paddr[2] == REG_VERTEX_COUNT) ? APB_DW'(r_vertex_count) : '0;

    // Live vertex count, clamped to the legal range
    always_comb begin
        w_n_live = r_vertex_count;
        if (r_vertex_count < CFG_W'(2)) begin
            w_n_live = CFG_W'(2);
        end else if (r_vertex_count > CFG_W'(LIVE_MAX)) begin
            w_n_live = CFG_W'(LIVE_MAX);
        end
    end
    assign w_last_idx = VIW'(w_n_live - CFG_W'(1));

    // Incoming edge: range filter, cost truncation, RAM address
    assign w_in_range = ({1'b0, i_from_vertex} < w_n_live) && ({1'b0, i_to_vertex} < w_n_live);
    assign w_cost_ext = 32'(i_edge_cost);
    assign w_cost     = w_cost_ext[COST_BITS-1:0];
    assign w_from_ext = {{AVW{1'b0}}, i_from_vertex};
    assign w_to_ext   = {{AVW{1'b0}}, i_to_vertex};
    assign w_s_ext    = {{AVW{1'b0}}, r_s};
    assign w_t_ext    = {{AVW{1'b0}}, r_t};

    // Edge store port selection: load or clearing pass write, scan reads
    assign w_mem_we    = (w_accept && w_in_range) || (r_state == ST_CLEAR);
    assign w_mem_waddr = (r_state == ST_CLEAR) ? r_clr
                       : {w_from_ext[AVW-1:0], w_to_ext[AVW-1:0]};
    assign w_mem_wdata = (r_state == ST_CLEAR) ? '0 : {1'b1, w_cost};
    assign w_mem_raddr = {w_s_ext[AVW-1:0], w_t_ext[AVW-1:0]};

    spt_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MEM_DEPTH)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Shared saturating add and compare against the round's best
    assign w_sum    = {1'b0, r_p_pc} + (TOTAL_W+1)'(w_mem_rdata[COST_BITS-1:0]);
    assign w_cand   = w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];
    assign w_better = r_p_vld && r_p_ok && w_mem_rdata[COST_BITS]
                   && (!r_found || (w_cand < r_best));

    // Scan position
    assign w_s_end = (r_s == r_last);
    assign w_t_end = (r_t == r_last);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (r_clr == '1) n_state = ST_IDLE;
            ST_IDLE:   if (w_accept && i_last_edge) n_state = ST_SCAN;
            ST_SCAN:   if (w_s_end && w_t_end) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_COMMIT;
            ST_COMMIT: n_state = r_found ? ST_SCAN : ST_EMIT;
            ST_EMIT:   if (r_v == r_last) n_state = ST_CLEAR;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer counters, settled mask, result strobe, config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VERTEX_COUNT_RST;
            r_clr          <= '0;
            r_s            <= '0;
            r_t            <= '0;
            r_v            <= '0;
            r_last         <= '0;
            r_settled      <= '0;
            r_found        <= 1'b0;
            r_p_vld        <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_vertex_count <= pwdata[CFG_W-1:0];
            end
            r_p_vld        <= (r_state == ST_SCAN);
            r_result_valid <= (r_state == ST_EMIT);
            if (w_better) begin
                r_found <= 1'b1;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + MEM_AW'(1);
                end
                ST_IDLE: begin
                    if (w_accept && i_last_edge) begin
                        r_settled <= LIVE_MAX'(1);
                        r_s       <= '0;
                        r_t       <= '0;
                        r_found   <= 1'b0;
                        r_last    <= w_last_idx;
                    end
                end
                ST_SCAN: begin
                    if (w_s_end) begin
                        r_s <= '0;
                        r_t <= r_t + VIW'(1);
                    end else begin
                        r_s <= r_s + VIW'(1);
                    end
                end
                ST_COMMIT: begin
                    if (r_found) begin
                        r_settled[r_best_t] <= 1'b1;
                    end
                    r_found <= 1'b0;
                    r_s     <= '0;
                    r_t     <= '0;
                    r_v     <= '0;
                end
                ST_EMIT: begin
                    r_v <= r_v + VIW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Vertex index and predecessor widened to the port width
    assign w_v_ext    = {{VERTEX_W{1'b0}}, r_v};
    assign w_pred_ext = {{VERTEX_W{1'b0}}, r_pred[r_v]};

    // Datapath: scan stage, best candidate, per-vertex cost and predecessor, result
    always_ff @(posedge i_clk) begin
        r_p_ok <= r_settled[r_s] && !r_settled[r_t];
        r_p_pc <= r_path_cost[r_s];
        r_p_s  <= r_s;
        r_p_t  <= r_t;
        if (w_better) begin
            r_best   <= w_cand;
            r_best_s <= r_p_s;
            r_best_t <= r_p_t;
        end
        if ((r_state == ST_IDLE) && w_accept && i_last_edge) begin
            r_path_cost[0] <= '0;
            r_pred[0]      <= '0;
        end
        if ((r_state == ST_COMMIT) && r_found) begin
            r_path_cost[r_best_t] <= r_best;
            r_pred[r_best_t]      <= r_best_s;
        end
        if (r_state == ST_EMIT) begin
            r_out_index   <= w_v_ext[VERTEX_W-1:0];
            r_out_reached <= r_settled[r_v];
            r_out_pred    <= r_settled[r_v] ? w_pred_ext[VERTEX_W-1:0] : '0;
            r_out_cost    <= r_settled[r_v] ? r_path_cost[r_v] : '1;
            r_out_last    <= (r_v == r_last);
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_vertex_index = r_out_index;
    assign o_predecessor  = r_out_pred;
    assign o_total_cost   = r_out_cost;
    assign o_reached      = r_out_reached;
    // last flag only while a result is on the ports
    assign o_last_result  = r_out_last && r_result_valid;

    // Checks
    `SPT_ASSERT(a_last_has_strobe, i_clk, i_rst_n, o_last_result |-> o_result_valid)
    `SPT_ASSERT(a_result_while_busy, i_clk, i_rst_n, o_result_valid |-> busy)
    `SPT_ASSERT(a_commit_settles_one, i_clk, i_rst_n, (r_state == ST_COMMIT) && r_found |=> $countones(r_settled) == $past($countones(r_settled)) + 1)
    `SPT_ASSERT(a_results_ascend, i_clk, i_rst_n, o_result_valid && !o_last_result |=> o_result_valid && (o_vertex_index == VERTEX_W'($past(o_vertex_index) + 5'd1)))

endmodule

@@ design/spt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module spt_ram #(
    parameter int unsigned WIDTH = 25,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
